@@ design/b64e_pkg.sv @@
// Shared types, constants and alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

   localparam logic [7:0] UPPER_BASE = 8'h41;  // 'A'
   localparam logic [7:0] LOWER_BASE = 8'h61;  // 'a'
   localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
   localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } rsp_type;

   // One accepted byte turned into up to four characters.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            msg_end;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] code;
      if (v < 6'd26) begin
         code = UPPER_BASE + {2'b00, v};
      end else if (v < 6'd52) begin
         code = LOWER_BASE + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         code = DIGIT_BASE + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         code = PLUS_CHAR;
      end else begin
         code = SLASH_CHAR;
      end
      return code;
   endfunction

endpackage

@@ design/b64e_front.sv @@
// Front end: tracks the 3-byte group phase and turns each byte into a character job.
`timescale 1ns / 1ps
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  b64e_pkg::req_type req_data,
   input  logic              take,
   output b64e_pkg::job_type job
);

   typedef enum logic [1:0] {
      PHASE_0,
      PHASE_1,
      PHASE_2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;
   logic       last;

   assign b    = req_data.data_byte;
   assign last = req_data.final_byte;

   always_comb begin
      job.chars    = {4{b64e_pkg::PAD_CHAR}};
      job.last_idx = 2'd0;
      job.msg_end  = last;
      phase_in     = PHASE_0;
      left_in      = 4'd0;
      unique case (phase_ff)
         PHASE_1: begin
            job.chars[0] = b64e_pkg::sextet_char({left_ff[1:0], b[7:4]});
            if (last) begin
               job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
               job.last_idx = 2'd2;
            end else begin
               phase_in = PHASE_2;
               left_in  = b[3:0];
            end
         end
         PHASE_2: begin
            job.chars[0] = b64e_pkg::sextet_char({left_ff, b[7:6]});
            job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
            job.last_idx = 2'd1;
         end
         default: begin
            // unreachable phase 3 behaves as phase 0
            job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
            if (last) begin
               job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
               job.last_idx = 2'd3;
            end else begin
               phase_in = PHASE_1;
               left_in  = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 4'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

@@ design/b64e_fifo.sv @@
// Two-entry job queue between the front end and the character sequencer.
`timescale 1ns / 1ps
module b64e_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   input  logic              pop,
   output b64e_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   b64e_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ design/b64e_back.sv @@
// Back end: walks each queued job, one character word per cycle unless stalled.
`timescale 1ns / 1ps
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  b64e_pkg::job_type head_job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff;
   b64e_pkg::rsp_type data_ff;
   logic              load, at_end;

   // a job is queued and the output slot is free or is being emptied this cycle
   assign load   = !empty && (!valid_ff || !rsp_stall);
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && at_end;
   assign idx_in = at_end ? 2'd0 : idx_ff + 2'd1;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.char_code  <= head_job.chars[idx_ff];
         data_ff.final_char <= head_job.msg_end && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= idx_in;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ design/base64_stream_encoder_core.sv @@
// Base64 encoder core: byte stream in, ASCII character stream out.
// The first character of a byte is registered in the job queue and then in the output word.
// The output sequencer sends one character per cycle while the output is not stalled; a byte
// gives one character (phase 0 or 1), two (phase 2) or three to four (last byte with padding).
// A two-entry job queue lets new bytes be taken while characters drain.
// Reset (synchronous) clears the group phase, leftover bits, queue and output valid flag.
`timescale 1ns / 1ps
module base64_stream_encoder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data
);

   b64e_pkg::job_type new_job, head_job;
   logic full, empty, take, pop;

   assign req_stall = full;
   assign take      = req_valid && !full;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .take     (take),
      .job      (new_job)
   );

   b64e_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_job (new_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the base64 stream encoder core.
`timescale 1ns / 1ps
module tb_top;

   localparam int HALF_PERIOD  = 5;
   localparam int TARGET_BYTES = 260;
   localparam int HOLD_CYCLES  = 120;
   localparam int HOLD_AT_CHAR = 150;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT  = 2000;

   // bytes held in the current 3-byte group
   localparam logic [1:0] GRP_EMPTY = 2'd0;
   localparam logic [1:0] GRP_ONE   = 2'd1;
   localparam logic [1:0] GRP_TWO   = 2'd2;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   b64e_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   b64e_pkg::rsp_type rsp_data;

   base64_stream_encoder_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   b64e_pkg::req_type pending_bytes[$];
   b64e_pkg::rsp_type expected_chars[$];
   logic [1:0] grp_phase = GRP_EMPTY;
   logic [3:0] grp_bits  = 4'h0;

   int error_count   = 0;
   int bytes_sent    = 0;
   int msgs_sent     = 0;
   int chars_checked = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      return b64_alphabet[v];
   endfunction

   function automatic void expect_char(input logic [7:0] code, input logic last);
      b64e_pkg::rsp_type c;
      c.char_code  = code;
      c.final_char = last;
      expected_chars.push_back(c);
   endfunction

   // Predicts the characters one input word produces and updates the group state.
   function automatic void encode_to_chars(input b64e_pkg::req_type r);
      logic [7:0] b;
      logic       fin;
      b   = r.data_byte;
      fin = r.final_byte;
      case (grp_phase)
         GRP_ONE: begin
            expect_char(b64_symbol({grp_bits[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               expect_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b1);
               grp_phase = GRP_EMPTY;
               grp_bits  = 4'h0;
            end else begin
               grp_phase = GRP_TWO;
               grp_bits  = b[3:0];
            end
         end
         GRP_TWO: begin
            expect_char(b64_symbol({grp_bits, b[7:6]}), 1'b0);
            expect_char(b64_symbol(b[5:0]), fin);
            grp_phase = GRP_EMPTY;
            grp_bits  = 4'h0;
         end
         default: begin
            // an unused phase code behaves as an empty group
            expect_char(b64_symbol(b[7:2]), 1'b0);
            if (fin) begin
               expect_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b0);
               expect_char(b64e_pkg::PAD_CHAR, 1'b1);
               grp_phase = GRP_EMPTY;
               grp_bits  = 4'h0;
            end else begin
               grp_phase = GRP_ONE;
               grp_bits  = {2'b00, b[1:0]};
            end
         end
      endcase
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic fin);
      b64e_pkg::req_type r;
      r.data_byte  = b;
      r.final_byte = fin;
      pending_bytes.push_back(r);
   endfunction

   // Driver: holds the word while stalled, otherwise offers the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_to_chars(req_data);
            bytes_sent++;
            if (req_data.final_byte) msgs_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_bytes.size() > 0 &&
                ((bytes_sent >= 80 && bytes_sent < 150) || $urandom_range(99) >= 8)) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted character and decides the next stall.
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      b64e_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected word, char_code", int'(rsp_data.char_code), 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_code !== want.char_code)
                  report_mismatch("char_code", int'(rsp_data.char_code),
                                  int'(want.char_code));
               if (rsp_data.final_char !== want.final_char)
                  report_mismatch("final_char", int'(rsp_data.final_char),
                                  int'(want.final_char));
            end
            chars_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && chars_checked >= HOLD_AT_CHAR) begin
            // long hold-off so the job queue fills and the input backs up
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (chars_checked >= 300 && chars_checked < 420) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 8);
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int len;
      int total;
      // one-byte messages at both data extremes: two pads each
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      // two-byte message reaching '+' and '/', one pad
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'hFF, 1'b1);
      // full groups, no padding
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h4D, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h6E, 1'b1);
      // digits, then a final byte starting a new group
      queue_byte(8'hD3, 1'b0);
      queue_byte(8'h5D, 1'b0);
      queue_byte(8'hB7, 1'b0);
      queue_byte(8'hE3, 1'b1);
      // five bytes: final byte lands mid-group
      queue_byte(8'h14, 1'b0);
      queue_byte(8'hFB, 1'b0);
      queue_byte(8'h9C, 1'b0);
      queue_byte(8'h03, 1'b0);
      queue_byte(8'hD9, 1'b1);

      total = pending_bytes.size();
      while (total < TARGET_BYTES) begin
         if ($urandom_range(9) == 0) len = $urandom_range(30, 9);
         else len = $urandom_range(8, 1);
         for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(255)), i == len - 1);
         total += len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d messages (%0d bytes) into %0d checked characters,",
               msgs_sent, bytes_sent, chars_checked);
      $display("with random stalls on both sides and one long output hold-off.");
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
